// ----- design/swc_pkg.sv -----
// shared types, constants and helpers for the slice window cache policy core
// no dependencies; imported by every module of the block
package swc_pkg;

  localparam int POSITION_BITS = 24;
  localparam int WINDOW_BITS   = 20;
  localparam int SLICES        = 4;

  localparam int RANGE_W   = 25;
  localparam int WIN_CFG_W = 21;
  localparam int TOT_CFG_W = 25;
  localparam int CNT_CFG_W = 3;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 2;

  localparam int SLICE_W = (POSITION_BITS > RANGE_W) ? POSITION_BITS : RANGE_W;
  localparam int CALC_W  = SLICE_W + 2;
  localparam int BUF_W   = $clog2(SLICES);
  localparam int HIT_W   = 5;

  localparam logic [HIT_W-1:0] PROMOTE_HITS = HIT_W'(20);
  localparam int OVERLAP_FAR = 9;

  localparam int MUL_IN_W    = 25;
  localparam int RECIP_W     = 32;
  localparam int PROD_W      = MUL_IN_W + RECIP_W;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  localparam logic [WIN_CFG_W-1:0] WIN_RESET   = 21'd65536;
  localparam logic [TOT_CFG_W-1:0] TOT_RESET   = 25'd0;
  localparam logic [CNT_CFG_W-1:0] COUNT_RESET = 3'd4;

  typedef struct packed {
    logic                     kind;
    logic [POSITION_BITS-1:0] position;
  } in_t;

  typedef struct packed {
    logic [BUF_W-1:0]       buffer_index;
    logic [WINDOW_BITS-1:0] offset;
    logic                   reload;
    logic [RANGE_W-1:0]     writeback_start;
    logic [RANGE_W-1:0]     writeback_end;
    logic [RANGE_W-1:0]     load_start;
    logic [RANGE_W-1:0]     load_end;
  } out_t;

  typedef struct packed {
    logic [SLICE_W-1:0] lo;
    logic [SLICE_W-1:0] hi;
    logic [BUF_W-1:0]   buf_idx;
  } slice_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_DIV10,
    ALU_CMP
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [CALC_W-1:0] a;
    logic [CALC_W-1:0] b;
    logic [CALC_W-1:0] c;
    logic [CALC_W-1:0] d;
  } alu_req_t;

  typedef struct packed {
    logic [CALC_W-1:0] sum;
    logic              lt0;
    logic              lt1;
  } alu_rsp_t;

  function automatic logic [CALC_W-1:0] ext_slice(logic [SLICE_W-1:0] x);
    return {{(CALC_W-SLICE_W){1'b0}}, x};
  endfunction

  function automatic logic [CALC_W-1:0] ext_pos(logic [POSITION_BITS-1:0] x);
    return {{(CALC_W-POSITION_BITS){1'b0}}, x};
  endfunction

  function automatic logic [CALC_W-1:0] ext_win(logic [WIN_CFG_W-1:0] x);
    return {{(CALC_W-WIN_CFG_W){1'b0}}, x};
  endfunction

  function automatic logic [CALC_W-1:0] ext_tot(logic [TOT_CFG_W-1:0] x);
    return {{(CALC_W-TOT_CFG_W){1'b0}}, x};
  endfunction

endpackage

// ----- design/swc_alu.sv -----
// shared arithmetic unit: add, subtract, divide by ten, two signed compares
// depends on swc_pkg
module swc_alu (
  input  swc_pkg::alu_req_t req_i,
  output swc_pkg::alu_rsp_t rsp_o
);
  import swc_pkg::*;

  logic [PROD_W-1:0] prod;

  assign prod = req_i.a[MUL_IN_W-1:0] * RECIP10;

  always_comb begin
    rsp_o.lt0 = $signed(req_i.a) < $signed(req_i.b);
    rsp_o.lt1 = $signed(req_i.c) < $signed(req_i.d);
    unique case (req_i.op)
      ALU_ADD:   rsp_o.sum = req_i.a + req_i.b;
      ALU_SUB:   rsp_o.sum = req_i.a - req_i.b;
      ALU_DIV10: rsp_o.sum = {{(CALC_W-(PROD_W-RECIP_SHIFT)){1'b0}},
                              prod[PROD_W-1:RECIP_SHIFT]};
      default:   rsp_o.sum = '0;
    endcase
  end

endmodule

// ----- design/slice_window_cache_policy_core.sv -----
// top level of the slice window cache policy: slice table, sequencer, result register
// depends on swc_pkg and swc_alu
//
// One transaction at a time runs through a sequencer that drives a single shared
// add/compare/divide-by-ten unit, one operation per cycle, and the input is not ready
// meanwhile. An access tests slices 0, 1, 2 and rotated slice 3 in turn until one
// hits, then takes the offset step; a reload adds the far test, scale, divide, start,
// end and clamp steps, an overlap test per other slice, a trim step for each one its
// new window overlaps, and the slice write. A lay-out runs an add and a write step
// per slice, then an all-zero result. A result that waits in the output register stalls
// only the final step, and the next transaction can be accepted while it waits.
module slice_window_cache_policy_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  swc_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output swc_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [swc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [swc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import swc_pkg::*;

  localparam int STATE_W = 5;
  localparam logic [STATE_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [STATE_W-1:0] ST_HOLD0 = 5'd1;
  localparam logic [STATE_W-1:0] ST_HOLD1 = 5'd2;
  localparam logic [STATE_W-1:0] ST_HOLD2 = 5'd3;
  localparam logic [STATE_W-1:0] ST_HOLD3 = 5'd4;
  localparam logic [STATE_W-1:0] ST_LTP   = 5'd5;
  localparam logic [STATE_W-1:0] ST_SCALE = 5'd6;
  localparam logic [STATE_W-1:0] ST_DIV   = 5'd7;
  localparam logic [STATE_W-1:0] ST_SUB   = 5'd8;
  localparam logic [STATE_W-1:0] ST_END   = 5'd9;
  localparam logic [STATE_W-1:0] ST_CLAMP = 5'd10;
  localparam logic [STATE_W-1:0] ST_TRIMA = 5'd11;
  localparam logic [STATE_W-1:0] ST_TRIMB = 5'd12;
  localparam logic [STATE_W-1:0] ST_WRITE = 5'd13;
  localparam logic [STATE_W-1:0] ST_OFF   = 5'd14;
  localparam logic [STATE_W-1:0] ST_LAYA  = 5'd15;
  localparam logic [STATE_W-1:0] ST_LAYB  = 5'd16;
  localparam logic [STATE_W-1:0] ST_ZERO  = 5'd17;

  localparam logic [BUF_W-1:0] LAST_IDX = BUF_W'(SLICES - 1);

  logic [STATE_W-1:0]       state_q, state_d;
  slice_t                   slc_q [SLICES];
  slice_t                   slc_d [SLICES];
  logic [HIT_W-1:0]         hit_q, hit_d;
  logic [WIN_CFG_W-1:0]     win_q;
  logic [TOT_CFG_W-1:0]     tot_q;
  logic [CNT_CFG_W-1:0]     cnt_q;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [CALC_W-1:0]        s_q, s_d, e_q, e_d, acc_q, acc_d;
  logic [BUF_W-1:0]         l_q, l_d, k_q, k_d;
  logic                     far_q, far_d, stop_q, stop_d, lay_ok_q, lay_ok_d;
  logic                     rl_q, rl_d;
  logic [RANGE_W-1:0]       wbs_q, wbs_d, wbe_q, wbe_d, lds_q, lds_d, lde_q, lde_d;
  out_t                     out_q, out_d;
  logic                     ov_q, ov_d;

  alu_req_t                 req;
  alu_rsp_t                 rsp;
  logic [BUF_W-1:0]         rd_idx;
  slice_t                   rd;
  logic                     hit;
  logic                     out_free;
  logic [HIT_W-1:0]         hit_inc;
  logic [CNT_CFG_W-1:0]     n_use;
  logic [WINDOW_BITS-1:0]   off_sat;

  swc_alu u_alu (
    .req_i (req),
    .rsp_o (rsp)
  );

  assign rd       = slc_q[rd_idx];
  assign hit      = !rsp.lt0 && rsp.lt1;
  assign out_free = !ov_q || out_ready_i;
  assign hit_inc  = hit_q + HIT_W'(1);
  assign n_use    = (cnt_q > CNT_CFG_W'(SLICES)) ? CNT_CFG_W'(SLICES) : cnt_q;

  always_comb begin
    if (rsp.sum[CALC_W-1]) begin
      off_sat = '0;
    end else if (|rsp.sum[CALC_W-2:WINDOW_BITS]) begin
      off_sat = '1;
    end else begin
      off_sat = rsp.sum[WINDOW_BITS-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    slc_d    = slc_q;
    hit_d    = hit_q;
    pos_d    = pos_q;
    s_d      = s_q;
    e_d      = e_q;
    acc_d    = acc_q;
    l_d      = l_q;
    k_d      = k_q;
    far_d    = far_q;
    stop_d   = stop_q;
    lay_ok_d = lay_ok_q;
    rl_d     = rl_q;
    wbs_d    = wbs_q;
    wbe_d    = wbe_q;
    lds_d    = lds_q;
    lde_d    = lde_q;
    out_d    = out_q;
    ov_d     = ov_q && !out_ready_i;
    rd_idx   = '0;
    req.op   = ALU_CMP;
    req.a    = ext_pos(pos_q);
    req.b    = ext_slice(rd.lo);
    req.c    = ext_pos(pos_q);
    req.d    = ext_slice(rd.hi);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pos_d = in_data_i.position;
          rl_d  = 1'b0;
          wbs_d = '0;
          wbe_d = '0;
          lds_d = '0;
          lde_d = '0;
          if (in_data_i.kind) begin
            hit_d  = '0;
            s_d    = '0;
            l_d    = '0;
            stop_d = 1'b0;
            for (int i = 0; i < SLICES; i++) begin
              slc_d[i].buf_idx = BUF_W'(i);
            end
            state_d = ST_LAYA;
          end else begin
            state_d = ST_HOLD0;
          end
        end
      end
      ST_HOLD0: begin
        rd_idx = BUF_W'(0);
        if (hit) begin
          k_d     = BUF_W'(0);
          state_d = ST_OFF;
        end else begin
          state_d = ST_HOLD1;
        end
      end
      ST_HOLD1: begin
        rd_idx = BUF_W'(1);
        if (hit) begin
          if (hit_inc == PROMOTE_HITS) begin
            slc_d[0] = slc_q[1];
            slc_d[1] = slc_q[0];
            hit_d    = '0;
            k_d      = BUF_W'(0);
          end else begin
            hit_d = hit_inc;
            k_d   = BUF_W'(1);
          end
          state_d = ST_OFF;
        end else begin
          hit_d   = '0;
          state_d = ST_HOLD2;
        end
      end
      ST_HOLD2: begin
        rd_idx = BUF_W'(2);
        if (hit) begin
          slc_d[0] = slc_q[2];
          for (int i = 1; i <= 2; i++) begin
            slc_d[i] = slc_q[i-1];
          end
          k_d     = BUF_W'(0);
          state_d = ST_OFF;
        end else begin
          slc_d[0] = slc_q[SLICES-1];
          for (int i = 1; i < SLICES; i++) begin
            slc_d[i] = slc_q[i-1];
          end
          state_d = ST_HOLD3;
        end
      end
      ST_HOLD3: begin
        rd_idx = BUF_W'(0);
        if (hit) begin
          k_d     = BUF_W'(0);
          state_d = ST_OFF;
        end else begin
          wbs_d   = rd.lo[RANGE_W-1:0];
          wbe_d   = rd.hi[RANGE_W-1:0];
          state_d = ST_LTP;
        end
      end
      ST_LTP: begin
        rd_idx  = BUF_W'(1);
        far_d   = rsp.lt0;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        // 9w as 8w + w for the far case
        req.op  = ALU_ADD;
        req.a   = far_q ? (ext_win(win_q) << 3) : ext_win(win_q);
        req.b   = far_q ? ext_win(win_q) : '0;
        acc_d   = rsp.sum;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        req.op  = ALU_DIV10;
        req.a   = acc_q;
        acc_d   = rsp.sum;
        state_d = ST_SUB;
      end
      ST_SUB: begin
        req.op  = ALU_SUB;
        req.a   = ext_pos(pos_q);
        req.b   = acc_q;
        s_d     = rsp.sum;
        state_d = ST_END;
      end
      ST_END: begin
        req.op  = ALU_ADD;
        req.a   = s_q;
        req.b   = ext_win(win_q);
        e_d     = rsp.sum;
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        req.c   = ext_tot(tot_q);
        req.d   = e_q;
        if (rsp.lt1) begin
          e_d = ext_tot(tot_q);
        end
        if (s_q[CALC_W-1]) begin
          s_d = '0;
        end
        l_d     = BUF_W'(1);
        state_d = ST_TRIMA;
      end
      ST_TRIMA: begin
        // overlap test: slice lo below e and slice hi above s
        rd_idx = l_q;
        req.a  = ext_slice(rd.lo);
        req.b  = e_q;
        req.c  = s_q;
        req.d  = ext_slice(rd.hi);
        if (rsp.lt0 && rsp.lt1) begin
          state_d = ST_TRIMB;
        end else if (l_q == LAST_IDX) begin
          state_d = ST_WRITE;
        end else begin
          l_d = l_q + BUF_W'(1);
        end
      end
      ST_TRIMB: begin
        rd_idx = l_q;
        req.a  = ext_pos(pos_q);
        req.b  = ext_slice(rd.hi);
        if (!rsp.lt0) begin
          s_d = ext_slice(rd.hi);
        end else begin
          e_d = ext_slice(rd.lo);
        end
        if (l_q == LAST_IDX) begin
          state_d = ST_WRITE;
        end else begin
          l_d     = l_q + BUF_W'(1);
          state_d = ST_TRIMA;
        end
      end
      ST_WRITE: begin
        slc_d[0].lo = s_q[SLICE_W-1:0];
        slc_d[0].hi = e_q[SLICE_W-1:0];
        rl_d        = 1'b1;
        lds_d       = s_q[RANGE_W-1:0];
        lde_d       = e_q[RANGE_W-1:0];
        k_d         = BUF_W'(0);
        state_d     = ST_OFF;
      end
      ST_OFF: begin
        rd_idx = k_q;
        req.op = ALU_SUB;
        req.a  = ext_pos(pos_q);
        req.b  = ext_slice(rd.lo);
        if (out_free) begin
          out_d.buffer_index    = rd.buf_idx;
          out_d.offset          = off_sat;
          out_d.reload          = rl_q;
          out_d.writeback_start = wbs_q;
          out_d.writeback_end   = wbe_q;
          out_d.load_start      = lds_q;
          out_d.load_end        = lde_q;
          ov_d                  = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      ST_LAYA: begin
        req.op   = ALU_ADD;
        req.a    = s_q;
        req.b    = ext_win(win_q);
        req.c    = s_q;
        req.d    = ext_tot(tot_q);
        acc_d    = rsp.sum;
        lay_ok_d = rsp.lt1;
        state_d  = ST_LAYB;
      end
      ST_LAYB: begin
        req.c = ext_tot(tot_q);
        req.d = acc_q;
        if ((CNT_CFG_W'(l_q) >= n_use) || stop_q || !lay_ok_q) begin
          if (CNT_CFG_W'(l_q) < n_use) begin
            stop_d = 1'b1;
          end
          slc_d[l_q].lo = '0;
          slc_d[l_q].hi = '0;
        end else begin
          slc_d[l_q].lo = s_q[SLICE_W-1:0];
          slc_d[l_q].hi = rsp.lt1 ? tot_q : acc_q[SLICE_W-1:0];
        end
        s_d = acc_q;
        if (l_q == LAST_IDX) begin
          state_d = ST_ZERO;
        end else begin
          l_d     = l_q + BUF_W'(1);
          state_d = ST_LAYA;
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          out_d   = '0;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      hit_q   <= '0;
      for (int i = 0; i < SLICES; i++) begin
        slc_q[i].lo      <= '0;
        slc_q[i].hi      <= '0;
        slc_q[i].buf_idx <= BUF_W'(i);
      end
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      hit_q   <= hit_d;
      slc_q   <= slc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
      tot_q <= TOT_RESET;
      cnt_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW: win_q <= cfg_data_i[WIN_CFG_W-1:0];
        CFG_TOTAL:  tot_q <= cfg_data_i[TOT_CFG_W-1:0];
        CFG_COUNT:  cnt_q <= cfg_data_i[CNT_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    s_q      <= s_d;
    e_q      <= e_d;
    acc_q    <= acc_d;
    l_q      <= l_d;
    k_q      <= k_d;
    far_q    <= far_d;
    stop_q   <= stop_d;
    lay_ok_q <= lay_ok_d;
    rl_q     <= rl_d;
    wbs_q    <= wbs_d;
    wbe_q    <= wbe_d;
    lds_q    <= lds_d;
    lde_q    <= lde_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/swc_checker.sv -----
// port-level checks for the slice window cache policy core, bound to the top level
// depends on swc_pkg
module swc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input swc_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input swc_pkg::out_t out_data_o
);
  import swc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accept");

  // a fresh result only comes out of a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work in flight");

  // no reload means no transfer ranges
  a_no_reload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reload |->
      out_data_o.writeback_start == '0 && out_data_o.writeback_end == '0 &&
      out_data_o.load_start == '0 && out_data_o.load_end == '0)
    else $error("ranges set without reload");

endmodule

bind slice_window_cache_policy_core swc_checker u_swc_checker (.*);

// ----- dv/slice_window_cache_policy_core_tb.sv -----
// testbench for slice_window_cache_policy_core: a directed table, then random phases
// checked against a behavioral slice cache predictor; depends on swc_pkg and the core rtl
module slice_window_cache_policy_core_tb;
  import swc_pkg::*;

  localparam logic   KIND_ACCESS = 1'b0;
  localparam logic   KIND_LAYOUT = 1'b1;
  localparam int     PROMOTE_RUN = 20;
  localparam longint FAR_TENTHS  = 9;
  localparam longint TENTHS      = 10;
  localparam longint POS_MAX     = 64'd16777215;
  localparam longint LEN_MAX     = 64'd16777216;
  localparam longint WIN_MAX     = 64'd1048576;
  localparam longint OFF_MAX     = 64'd1048575;
  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 125;
  localparam int     IDLE_GAP    = 24;
  localparam int     TAIL        = 40;
  localparam int     LIMIT       = 400000;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e          rk;
    logic               kind;
    logic [23:0]        pos;
    logic [1:0]         idx;
    logic [24:0]        val;
    out_t               want;
  } row_t;

  localparam out_t ALL_ZERO   = '0;
  localparam out_t MISS_EMPTY3 = {2'd3, 20'd0, 1'b1, 100'd0};
  localparam out_t MISS_EMPTY2 = {2'd2, 20'd0, 1'b1, 100'd0};

  row_t plan[$] = '{
    '{ROW_TYPED, KIND_ACCESS, 24'd0,        CFG_WINDOW, 25'd0,        MISS_EMPTY3},
    '{ROW_TYPED, KIND_ACCESS, 24'd0,        CFG_WINDOW, 25'd0,        MISS_EMPTY2},
    '{ROW_TYPED, KIND_LAYOUT, 24'd0,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd16777215, CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_WINDOW, 25'd10,       ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_TOTAL,  25'd35,       ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_COUNT,  25'd4,        ALL_ZERO},
    '{ROW_TYPED, KIND_LAYOUT, 24'hFFFFFF,   CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd0,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd15,       CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd25,       CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd34,       CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd35,       CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd5,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd16777215, CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_COUNT,  25'd0,        ALL_ZERO},
    '{ROW_TYPED, KIND_LAYOUT, 24'd0,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd3,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_WINDOW, 25'd1048576,  ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_TOTAL,  25'd16777216, ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_COUNT,  25'd7,        ALL_ZERO},
    '{ROW_TYPED, KIND_LAYOUT, 24'd0,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd16777215, CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd0,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd1048576,  CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_WINDOW, 25'd1,        ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_TOTAL,  25'd3,        ALL_ZERO},
    '{ROW_CFG,   KIND_ACCESS, 24'd0,        CFG_COUNT,  25'd1,        ALL_ZERO},
    '{ROW_TYPED, KIND_LAYOUT, 24'd0,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd0,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd2,        CFG_WINDOW, 25'd0,        ALL_ZERO},
    '{ROW_ITEM,  KIND_ACCESS, 24'd1,        CFG_WINDOW, 25'd0,        ALL_ZERO}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // predictor copy of the slice table and registers
  longint     sl_lo[4];
  longint     sl_hi[4];
  logic [1:0] sl_buf[4];
  int         hit_run     = 0;
  longint     win_len     = 64'd65536;
  longint     chan_len    = 0;
  int         slices_used = 4;

  out_t pending[$];
  out_t oldest;
  int   mismatches  = 0;
  int   cycle_count = 0;
  int   stall_left  = 0;
  int   burst_left  = 0;
  bit   calm        = 1'b0;

  slice_window_cache_policy_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit covers(int k, longint p);
    return sl_lo[k] <= p && p < sl_hi[k];
  endfunction

  function automatic void to_head(int k);
    longint     lo;
    longint     hi;
    logic [1:0] b;
    lo = sl_lo[k];
    hi = sl_hi[k];
    b  = sl_buf[k];
    for (int i = k; i > 0; i--) begin
      sl_lo[i]  = sl_lo[i-1];
      sl_hi[i]  = sl_hi[i-1];
      sl_buf[i] = sl_buf[i-1];
    end
    sl_lo[0]  = lo;
    sl_hi[0]  = hi;
    sl_buf[0] = b;
  endfunction

  function automatic void note_hit(inout out_t r, input int k, input longint p);
    longint off;
    off = p - sl_lo[k];
    if (off < 0) off = 0;
    if (off > OFF_MAX) off = OFF_MAX;
    r.buffer_index = sl_buf[k];
    r.offset       = 20'(off);
  endfunction

  function automatic out_t cache_lookup(in_t it);
    out_t   r;
    longint p;
    longint s;
    longint e;
    int     n;
    bit     stop;
    r    = '0;
    p    = longint'(it.position);
    stop = 1'b0;
    if (it.kind == KIND_LAYOUT) begin
      n = (slices_used > 4) ? 4 : slices_used;
      hit_run = 0;
      for (int i = 0; i < 4; i++) begin
        s = i * win_len;
        e = s + win_len;
        sl_buf[i] = 2'(i);
        if (i >= n || stop || s >= chan_len) begin
          if (i < n) stop = 1'b1;
          sl_lo[i] = 0;
          sl_hi[i] = 0;
        end else begin
          if (e > chan_len) e = chan_len;
          sl_lo[i] = s;
          sl_hi[i] = e;
        end
      end
      return r;
    end
    if (covers(0, p)) begin
      note_hit(r, 0, p);
      return r;
    end
    if (covers(1, p)) begin
      hit_run++;
      if (hit_run == PROMOTE_RUN) begin
        to_head(1);
        hit_run = 0;
        note_hit(r, 0, p);
      end else begin
        note_hit(r, 1, p);
      end
      return r;
    end
    hit_run = 0;
    if (covers(2, p)) begin
      to_head(2);
      note_hit(r, 0, p);
      return r;
    end
    to_head(3);
    if (!covers(0, p)) begin
      r.writeback_start = 25'(sl_lo[0]);
      r.writeback_end   = 25'(sl_hi[0]);
      if (p < sl_lo[1]) s = p - (win_len * FAR_TENTHS) / TENTHS;
      else s = p - win_len / TENTHS;
      e = s + win_len;
      if (s < 0) s = 0;
      if (e > chan_len) e = chan_len;
      for (int l = 1; l < 4; l++) begin
        if (sl_lo[l] < e && sl_hi[l] > s) begin
          if (sl_hi[l] <= p) s = sl_hi[l];
          else e = sl_lo[l];
        end
      end
      sl_lo[0]     = s;
      sl_hi[0]     = e;
      r.reload     = 1'b1;
      r.load_start = 25'(s);
      r.load_end   = 25'(e);
    end
    note_hit(r, 0, p);
    return r;
  endfunction

  // most accesses land in or next to a live slice; runs on slice 1 reach promotion
  function automatic in_t pick_item();
    in_t    it;
    int     k;
    int     roll;
    longint p;
    longint top;
    it.kind = KIND_ACCESS;
    roll = $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    top = chan_len + win_len;
    if (top > POS_MAX) top = POS_MAX;
    if (burst_left > 0) begin
      burst_left--;
      k = 1;
      roll = 10;
    end else if ($urandom_range(0, 39) == 0) begin
      burst_left = 24;
    end
    if (roll < 5) it.kind = KIND_LAYOUT;
    if (roll < 45) begin
      if (sl_hi[k] > sl_lo[k]) p = sl_lo[k] + $urandom_range(0, 32'(sl_hi[k] - sl_lo[k] - 1));
      else p = $urandom_range(0, 32'(top));
    end else if (roll < 65) begin
      case ($urandom_range(0, 5))
        0: p = sl_lo[k] - 1;
        1: p = sl_lo[k];
        2: p = sl_hi[k] - 1;
        3: p = sl_hi[k];
        4: p = chan_len - 1;
        default: p = chan_len;
      endcase
    end else if (roll < 92) begin
      p = $urandom_range(0, 32'(top));
    end else begin
      p = longint'($urandom) & POS_MAX;
    end
    if (p < 0) p = 0;
    if (p > POS_MAX) p = POS_MAX;
    it.position = 24'(p);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic send_item(input in_t it, input bit typed, input out_t want);
    int   gap;
    out_t r;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    r = cache_lookup(it);
    pending.push_back(typed ? want : r);
  endtask

  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_WINDOW: win_len = longint'(data[WIN_CFG_W-1:0]);
      CFG_TOTAL:  chan_len = longint'(data[TOT_CFG_W-1:0]);
      CFG_COUNT:  slices_used = int'(data[CNT_CFG_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending.size() == 0) begin
        report_mismatch("result with no transaction outstanding", 64'(out_data_o), '0);
      end else begin
        oldest = pending.pop_front();
        if (out_data_o.buffer_index !== oldest.buffer_index)
          report_mismatch("buffer_index", 64'(out_data_o.buffer_index),
                          64'(oldest.buffer_index));
        if (out_data_o.offset !== oldest.offset)
          report_mismatch("offset", 64'(out_data_o.offset), 64'(oldest.offset));
        if (out_data_o.reload !== oldest.reload)
          report_mismatch("reload", 64'(out_data_o.reload), 64'(oldest.reload));
        if (out_data_o.writeback_start !== oldest.writeback_start)
          report_mismatch("writeback_start", 64'(out_data_o.writeback_start),
                          64'(oldest.writeback_start));
        if (out_data_o.writeback_end !== oldest.writeback_end)
          report_mismatch("writeback_end", 64'(out_data_o.writeback_end),
                          64'(oldest.writeback_end));
        if (out_data_o.load_start !== oldest.load_start)
          report_mismatch("load_start", 64'(out_data_o.load_start),
                          64'(oldest.load_start));
        if (out_data_o.load_end !== oldest.load_end)
          report_mismatch("load_end", 64'(out_data_o.load_end), 64'(oldest.load_end));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_t         it;
    longint      wsel;
    longint      tsel;
    longint      cap;
    int          csel;
    int          roll;
    logic [24:0] data;
    for (int i = 0; i < 4; i++) begin
      sl_lo[i]  = 0;
      sl_hi[i]  = 0;
      sl_buf[i] = 2'(i);
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      it.kind     = plan[i].kind;
      it.position = plan[i].pos;
      case (plan[i].rk)
        ROW_CFG: begin
          settle_block();
          cfg_write(plan[i].idx, plan[i].val);
        end
        ROW_ITEM: send_item(it, 1'b0, '0);
        default:  send_item(it, 1'b1, plan[i].want);
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      roll = $urandom_range(0, 19);
      if (roll < 8) wsel = $urandom_range(1, 16);
      else if (roll < 14) wsel = $urandom_range(17, 200);
      else if (roll < 17) wsel = $urandom_range(201, 70000);
      else if (roll < 19) wsel = WIN_MAX;
      else wsel = 1;
      data = 25'(wsel);
      if ($urandom_range(0, 3) == 0) data[24:21] = 4'($urandom);
      cfg_write(CFG_WINDOW, data);
      cap = wsel * 5;
      if (cap > LEN_MAX) cap = LEN_MAX;
      case ($urandom_range(0, 5))
        0: tsel = 0;
        1: tsel = LEN_MAX;
        2: tsel = $urandom_range(0, 32'(LEN_MAX));
        default: tsel = $urandom_range(0, 32'(cap));
      endcase
      cfg_write(CFG_TOTAL, 25'(tsel));
      csel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      data = 25'(csel);
      if ($urandom_range(0, 3) == 0) data[24:3] = 22'($urandom);
      cfg_write(CFG_COUNT, data);
      calm = (phase == PHASES - 1);
      if ($urandom_range(0, 4) != 0) begin
        it          = '0;
        it.kind     = KIND_LAYOUT;
        it.position = 24'($urandom);
        send_item(it, 1'b0, '0);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender until the block has drained
        if (phase == 2 && n == PHASE_ITEMS / 2) settle_block();
        send_item(pick_item(), 1'b0, '0);
      end
    end

    settle_block();
    repeat (TAIL) @(posedge clk_i);
    if (pending.size() != 0) report_mismatch("results never arrived", 64'(pending.size()), '0);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/swc_pkg.sv
design/swc_alu.sv
design/slice_window_cache_policy_core.sv
design/swc_checker.sv
dv/slice_window_cache_policy_core_tb.sv
